[rtl/core/xrng_pkg.sv]
// Package with shared types, command codes and constants for the xoshiro256** generator.
package xrng_pkg;

    localparam int WordW = 64;
    localparam int HalfW = 32;

    typedef logic [WordW-1:0] word_t;
    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_SEED  = 2'd0;
    localparam cmd_t CMD_RAW   = 2'd1;
    localparam cmd_t CMD_BELOW = 2'd2;

    localparam word_t GOLDEN_INC = 64'h9e3779b97f4a7c15;
    localparam word_t MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
    localparam word_t MIX_MUL_B  = 64'h94d049bb133111eb;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MASK,
        ST_DRAW,
        ST_SCALE,
        ST_CHECK,
        ST_MIX_ADD,
        ST_MIX_MUL_A,
        ST_MIX_MUL_B
    } state_t;

    typedef struct packed {
        logic       draw;
        logic       load;
        logic [1:0] idx;
    } xrng_st_ctrl_t;

    function automatic word_t smear(input word_t w);
        word_t m;
        m = w;
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        m = m | (m >> 16);
        m = m | (m >> 32);
        return m;
    endfunction

endpackage

[rtl/core/xrng_mul.sv]
// Iterative 64-bit multiplier giving the low product word from one 32x32 multiplier.
module xrng_mul
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  xrng_pkg::word_t      a,
    input  xrng_pkg::word_t      b,
    output logic                 done,
    output xrng_pkg::word_t      product
);
    import xrng_pkg::*;

    word_t               a_reg;
    word_t               b_reg;
    word_t               acc_reg;
    word_t               acc_next;
    logic [1:0]          step_reg;
    logic                run_reg;
    logic                done_reg;
    logic [HalfW-1:0]    op_x;
    logic [HalfW-1:0]    op_y;
    logic [WordW-1:0]    part;
    word_t               term;

    always_comb
    begin
        op_x = a_reg[HalfW-1:0];
        op_y = b_reg[HalfW-1:0];
        case (step_reg)
            2'd1:    op_y = b_reg[WordW-1:HalfW];
            2'd2:    op_x = a_reg[WordW-1:HalfW];
            default: op_x = a_reg[HalfW-1:0];
        endcase
        part = {{HalfW{1'b0}}, op_x} * {{HalfW{1'b0}}, op_y};
        if (step_reg == 2'd0)
        begin
            term = part;
        end
        else
        begin
            term = {part[HalfW-1:0], {HalfW{1'b0}}};
        end
        acc_next = acc_reg + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            done_reg <= run_reg && (step_reg == 2'd2);
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

[rtl/core/xrng_state.sv]
// Generator state words with the xoshiro256 step and seed loading.
module xrng_state
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  xrng_pkg::xrng_st_ctrl_t ctrl,
    input  xrng_pkg::word_t         load_word,
    output xrng_pkg::word_t         s1
);
    import xrng_pkg::*;

    word_t gen_reg [4];
    word_t gen_next [4];
    word_t t2;
    word_t t3;

    always_comb
    begin
        gen_next = gen_reg;
        t2 = gen_reg[2] ^ gen_reg[0];
        t3 = gen_reg[3] ^ gen_reg[1];
        if (ctrl.draw)
        begin
            gen_next[1] = gen_reg[1] ^ t2;
            gen_next[0] = gen_reg[0] ^ t3;
            gen_next[2] = t2 ^ (gen_reg[1] << 17);
            gen_next[3] = {t3[18:0], t3[63:19]};
        end
        else if (ctrl.load)
        begin
            gen_next[ctrl.idx] = load_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                gen_reg[i] <= '0;
            end
        end
        else
        begin
            gen_reg <= gen_next;
        end
    end

    assign s1 = gen_reg[1];

endmodule

[rtl/core/xoshiro256ss_rng_with_bounded_draw.sv]
// Top level of the xoshiro256** generator with seeding and unbiased bounded draw.
// A raw draw runs mask, draw, scale and check, which registers the word once the output is free.
// A bounded draw repeats draw, scale and check per rejection; a bound below two skips to check.
// Seeding uses the shared multiplier twice per state word.
// A result word waits in an output register while the next command is accepted.
// Reset clears all four state words to zero and empties the output register.
module xoshiro256ss_rng_with_bounded_draw
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [63:0] operand
    input  logic [1:0]  s_axis_tuser,  // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // [63:0] value
);
    import xrng_pkg::*;

    state_t        state_reg;
    state_t        state_next;
    cmd_t          cmd_reg;
    cmd_t          cmd_next;
    word_t         n_reg;
    word_t         n_next;
    word_t         mask_reg;
    word_t         mask_next;
    word_t         tmp_reg;
    word_t         tmp_next;
    word_t         val_reg;
    word_t         val_next;
    word_t         acc_reg;
    word_t         acc_next;
    logic [1:0]    idx_reg;
    logic [1:0]    idx_next;
    word_t         out_reg;
    word_t         out_next;
    logic          out_valid_reg;
    logic          out_valid_next;

    xrng_st_ctrl_t st_ctrl;
    word_t         load_word;
    word_t         s1;
    logic          mul_start;
    word_t         mul_a;
    word_t         mul_b;
    logic          mul_done;
    word_t         mul_prod;

    word_t         sum;
    word_t         s1x5;
    word_t         scaled;
    logic          n_small;
    logic          hit;
    logic          out_free;

    assign n_small  = (n_reg[63:1] == '0);
    assign hit      = (cmd_reg == CMD_RAW) || n_small || (val_reg < n_reg);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign sum      = acc_reg + GOLDEN_INC;
    assign s1x5     = s1 + (s1 << 2);
    assign scaled   = tmp_reg + (tmp_reg << 3);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        CMD_SEED:  state_next = ST_MIX_ADD;
                        CMD_RAW:   state_next = ST_MASK;
                        CMD_BELOW: state_next = ST_MASK;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MASK:
            begin
                if ((cmd_reg == CMD_BELOW) && n_small)
                begin
                    state_next = ST_CHECK;
                end
                else
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (!hit)
                begin
                    state_next = ST_DRAW;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MIX_ADD: state_next = ST_MIX_MUL_A;
            ST_MIX_MUL_A:
            begin
                if (mul_done)
                begin
                    state_next = ST_MIX_MUL_B;
                end
            end
            ST_MIX_MUL_B:
            begin
                if (mul_done)
                begin
                    state_next = (idx_reg == 2'd3) ? ST_IDLE : ST_MIX_ADD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        n_next         = n_reg;
        mask_next      = mask_reg;
        tmp_next       = tmp_reg;
        val_next       = val_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        st_ctrl        = '0;
        load_word      = mul_prod ^ (mul_prod >> 31);
        mul_start      = 1'b0;
        mul_a          = sum ^ (sum >> 30);
        mul_b          = MIX_MUL_A;
        s_axis_tready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd_next      = s_axis_tuser;
                n_next        = s_axis_tdata;
                acc_next      = s_axis_tdata;
                idx_next      = 2'd0;
            end
            ST_MASK:
            begin
                mask_next = (cmd_reg == CMD_RAW) ? '1 : smear(n_reg - 64'd1);
                val_next  = '0;
            end
            ST_DRAW:
            begin
                st_ctrl.draw = 1'b1;
                tmp_next     = {s1x5[56:0], s1x5[63:57]};
            end
            ST_SCALE:
            begin
                val_next = scaled & mask_reg;
            end
            ST_CHECK:
            begin
                if (hit && out_free)
                begin
                    out_next       = val_reg;
                    out_valid_next = 1'b1;
                end
            end
            ST_MIX_ADD:
            begin
                acc_next  = sum;
                mul_start = 1'b1;
            end
            ST_MIX_MUL_A:
            begin
                if (mul_done)
                begin
                    mul_start = 1'b1;
                    mul_a     = mul_prod ^ (mul_prod >> 27);
                    mul_b     = MIX_MUL_B;
                end
            end
            ST_MIX_MUL_B:
            begin
                if (mul_done)
                begin
                    st_ctrl.load = 1'b1;
                    st_ctrl.idx  = idx_reg;
                    idx_next     = idx_reg + 2'd1;
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            cmd_reg       <= CMD_SEED;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            cmd_reg       <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        mask_reg <= mask_next;
        tmp_reg  <= tmp_next;
        val_reg  <= val_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
    end

    xrng_state u_state
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (st_ctrl),
        .load_word (load_word),
        .s1        (s1)
    );

    xrng_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule

[rtl/core/xrng_checker.sv]
// Port-level checker for the xoshiro256** generator, bound to the top level.
module xrng_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    import xrng_pkg::*;

    // A real command keeps the block busy for at least the next cycle.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready &&
         (s_axis_tuser == CMD_SEED || s_axis_tuser == CMD_RAW ||
          s_axis_tuser == CMD_BELOW)) |=> !s_axis_tready)
        else $error("input accepted again right after a command");

    // A new word only appears while a command is being worked on.
    a_word_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("output word appeared without work in progress");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output word withdrawn before it was taken");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("output word changed while stalled");

endmodule

bind xoshiro256ss_rng_with_bounded_draw xrng_checker u_xrng_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
